// ===== rtl/dq_pkg.sv =====
package dq_pkg;

  // Queue capacity and derived widths
  localparam int DEPTH  = 16;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  // One access to the entry store
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [PTR_W-1:0]  addr;
    logic [DATA_W-1:0] wr_data;
  } mem_req_t;

  // Status of the beat that sits in the output register
  typedef struct packed {
    logic pop_ok;
    logic rejected;
    logic empty_after;
    logic full_after;
  } res_flags_t;

endpackage

// ===== rtl/dq_if.sv =====
interface dq_in_if;
  import dq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, operation, push_value, input ready);
  modport sink   (input valid, operation, push_value, output ready);
endinterface

interface dq_out_if;
  import dq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic                     rejected;
  logic                     empty_after;
  logic                     full_after;

  modport source (output valid, popped_value, rejected, empty_after, full_after,
                  input ready);
  modport sink   (input valid, popped_value, rejected, empty_after, full_after,
                  output ready);
endinterface

// ===== rtl/dq_ram.sv =====
module dq_ram #(
  parameter int WIDTH   = 32,
  parameter int ENTRIES = 16,
  parameter int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wr_data,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [ENTRIES];
  logic [WIDTH-1:0] rd_data_r;

  // Single port, registered read; data holds until the next read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/dq_ctrl.sv =====
module dq_ctrl
  import dq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        operation,
  input  logic [DATA_W-1:0] push_value,
  output mem_req_t          mem_req,
  output res_flags_t        flags
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]   DEPTH_X = (CNT_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  res_flags_t       flags_r, flags_nxt;

  logic             is_full, is_empty;
  logic [PTR_W-1:0] front_dec, front_inc, back_slot, tail_slot;
  logic [CNT_W:0]   back_sum, tail_sum;

  assign is_full  = (count_r == DEPTH_C);
  assign is_empty = (count_r == '0);

  // Ring positions, wrapped with one compare and subtract
  assign front_dec = (front_r == '0) ? LAST_C : front_r - PTR_W'(1);
  assign front_inc = (front_r == LAST_C) ? '0 : front_r + PTR_W'(1);
  assign back_sum  = (CNT_W + 1)'(front_r) + (CNT_W + 1)'(count_r);
  assign tail_sum  = back_sum - (CNT_W + 1)'(1);
  assign back_slot = (back_sum >= DEPTH_X) ? PTR_W'(back_sum - DEPTH_X) : PTR_W'(back_sum);
  assign tail_slot = (tail_sum >= DEPTH_X) ? PTR_W'(tail_sum - DEPTH_X) : PTR_W'(tail_sum);

  // Decode one operation into a store access and the new pointers
  always_comb begin
    front_nxt       = front_r;
    count_nxt       = count_r;
    flags_nxt       = flags_r;
    mem_req.wr_en   = 1'b0;
    mem_req.rd_en   = 1'b0;
    mem_req.addr    = front_r;
    mem_req.wr_data = push_value;
    if (accept) begin
      flags_nxt.pop_ok   = 1'b0;
      flags_nxt.rejected = 1'b0;
      unique case (op_t'(operation))
        OP_PUSH_FRONT: begin
          if (is_full) begin
            flags_nxt.rejected = 1'b1;
          end else begin
            front_nxt     = front_dec;
            count_nxt     = count_r + CNT_W'(1);
            mem_req.wr_en = 1'b1;
            mem_req.addr  = front_dec;
          end
        end
        OP_PUSH_BACK: begin
          if (is_full) begin
            flags_nxt.rejected = 1'b1;
          end else begin
            count_nxt     = count_r + CNT_W'(1);
            mem_req.wr_en = 1'b1;
            mem_req.addr  = back_slot;
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            flags_nxt.rejected = 1'b1;
          end else begin
            front_nxt        = front_inc;
            count_nxt        = count_r - CNT_W'(1);
            mem_req.rd_en    = 1'b1;
            mem_req.addr     = front_r;
            flags_nxt.pop_ok = 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (is_empty) begin
            flags_nxt.rejected = 1'b1;
          end else begin
            count_nxt        = count_r - CNT_W'(1);
            mem_req.rd_en    = 1'b1;
            mem_req.addr     = tail_slot;
            flags_nxt.pop_ok = 1'b1;
          end
        end
        default: begin
          flags_nxt.rejected = 1'b1;
        end
      endcase
      flags_nxt.empty_after = (count_nxt == '0);
      flags_nxt.full_after  = (count_nxt == DEPTH_C);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      flags_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign flags = flags_r;

  // Occupancy and pointer stay in range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("entry count above capacity");

  a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= LAST_C) else $error("front pointer out of range");

  // A taken push grows the queue by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !operation[1] && !is_full |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not grow the queue");

  // A store access only happens on an accepted beat, never both kinds at once
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.wr_en || mem_req.rd_en) |-> accept && !(mem_req.wr_en && mem_req.rd_en))
    else $error("stray store access");

endmodule

// ===== rtl/double_ended_queue.sv =====
// Channel | Dir | Payload                                          | Beat on
// in_ch   | in  | operation[1:0], push_value[31:0] signed          | valid && ready
// out_ch  | out | popped_value[31:0] signed, rejected, empty_after, | valid && ready
//         |     | full_after                                       |
// One operation per cycle unless out_ch stalls; the result appears in the cycle after
// its input beat, when the entry store's registered read data is ready.
// The store is a single-port memory; the one access per operation sets the rate.
// rst_n (synchronous) empties the queue; store contents are not cleared.
// in_ch.ready drops only while a result waits and out_ch.ready is low.
module double_ended_queue
  import dq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dq_in_if.sink     in_ch,
  dq_out_if.source  out_ch
);

  logic              accept;
  logic              out_valid_r;
  mem_req_t          mem_req;
  res_flags_t        flags;
  logic [DATA_W-1:0] rd_data;

  // Next beat may enter as soon as the output register is free or being taken
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  dq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .operation  (in_ch.operation),
    .push_value (in_ch.push_value),
    .mem_req    (mem_req),
    .flags      (flags)
  );

  dq_ram #(
    .WIDTH   (DATA_W),
    .ENTRIES (DEPTH),
    .ADDR_W  (PTR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .rd_en   (mem_req.rd_en),
    .addr    (mem_req.addr),
    .wr_data (mem_req.wr_data),
    .rd_data (rd_data)
  );

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = flags.pop_ok ? rd_data : '0;
  assign out_ch.rejected     = flags.rejected;
  assign out_ch.empty_after  = flags.empty_after;
  assign out_ch.full_after   = flags.full_after;

  // Queue cannot be both empty and full
  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(flags.empty_after && flags.full_after))
    else $error("queue reported empty and full");

  // A refused beat never carries data
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && flags.rejected |-> out_ch.popped_value == '0)
    else $error("rejected beat carries a value");

endmodule
